// ===== hw/rtl/dense_to_sparse_compressor_core_assert.svh =====
// ----------------------------------------------------------------------------
// dense to sparse compressor assertion macros
// clocked property checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DENSE_TO_SPARSE_COMPRESSOR_CORE_ASSERT_SVH
`define DENSE_TO_SPARSE_COMPRESSOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define DTSC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, held off during reset
`define DTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DTSC_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define DTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsc_pkg
// shared types and constants of the dense to sparse compressor
// ----------------------------------------------------------------------------
`default_nettype none

package dtsc_pkg;

	// largest matrix the index counters cover
	localparam int unsigned MAX_ROWS = 256;
	localparam int unsigned MAX_COLS = 256;

	localparam int unsigned DIM_W   = 9;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned SLOT_W  = 17;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned REG_W   = 2;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [REG_W-1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [REG_W-1:0] REG_ZERO_VALUE   = 2'd2;

	typedef enum logic [2:0] {
		KIND_ZERO    = 3'd0,
		KIND_ROWPTR  = 3'd1,
		KIND_DIAG    = 3'd2,
		KIND_OFFDIAG = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	// matrix shape after saturation
	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} dims_t;

	// one result beat, value travels beside it
	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  address;
		logic [IDX_W-1:0]   column;
		logic [SLOT_W-1:0]  pointer;
		logic [COUNT_W-1:0] nonzero_count;
		logic               last;
	} res_meta_t;

	// up to three results caused by one element
	typedef struct packed {
		res_meta_t [2:0] meta;
		logic [1:0]      count;
	} res_set_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtsc_if.sv =====
// ----------------------------------------------------------------------------
// dtsc channel interfaces
// valid/ready channels for dense elements and sparse result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsc_in_if #(
	parameter int unsigned DATA_WIDTH = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface dtsc_out_if #(
	parameter int unsigned DATA_WIDTH = 32
) ();
	logic                               valid;
	logic                               ready;
	logic [2:0]                         kind;
	logic [dtsc_pkg::SLOT_W-1:0]        address;
	logic [dtsc_pkg::IDX_W-1:0]         column;
	logic signed [DATA_WIDTH-1:0]       value;
	logic [dtsc_pkg::SLOT_W-1:0]        pointer;
	logic [dtsc_pkg::COUNT_W-1:0]       nonzero_count;
	logic                               last;

	modport source (
		output valid, output kind, output address, output column, output value,
		output pointer, output nonzero_count, output last, input ready
	);
	modport sink (
		input valid, input kind, input address, input column, input value,
		input pointer, input nonzero_count, input last, output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/dtsc_gen.sv =====
// ----------------------------------------------------------------------------
// dtsc_gen
// matrix position tracking and result set generation for one element
// ----------------------------------------------------------------------------
`default_nettype none
`include "dense_to_sparse_compressor_core_assert.svh"

module dtsc_gen #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid,
	input  wire logic                  consume,
	input  wire logic [DATA_WIDTH-1:0] element,
	input  wire dtsc_pkg::dims_t       dims,
	input  wire logic [DATA_WIDTH-1:0] zero_value,
	output dtsc_pkg::res_set_t         set,
	output logic [DATA_WIDTH-1:0]      vals [3]
);

	logic [dtsc_pkg::IDX_W-1:0]  row_q;
	logic [dtsc_pkg::IDX_W-1:0]  col_q;
	logic [dtsc_pkg::SLOT_W-1:0] next_slot_q;
	logic [dtsc_pkg::SLOT_W-1:0] offdiag_q;

	logic                        first;
	logic                        row_end;
	logic                        mat_end;
	logic                        is_diag;
	logic                        is_off;
	logic [dtsc_pkg::SLOT_W-1:0] ns0;
	logic [dtsc_pkg::SLOT_W-1:0] ns1;
	logic [dtsc_pkg::SLOT_W-1:0] cnt0;
	logic [dtsc_pkg::SLOT_W-1:0] cnt1;
	logic [3:0]                  cand_v;
	dtsc_pkg::res_meta_t         cand_m [4];
	logic [DATA_WIDTH-1:0]       cand_d [4];

	always_comb begin
		first   = (row_q == '0) && (col_q == '0);
		row_end = ({1'b0, col_q} + 9'd1) >= dims.cols;
		mat_end = row_end && (({1'b0, row_q} + 9'd1) >= dims.rows);
		is_diag = (row_q == col_q);
		is_off  = !is_diag && (element != zero_value);
		ns0     = first ? (dtsc_pkg::SLOT_W'(dims.rows) + 17'd1) : next_slot_q;
		cnt0    = first ? '0 : offdiag_q;
		ns1     = ns0 + dtsc_pkg::SLOT_W'(is_off);
		cnt1    = cnt0 + dtsc_pkg::SLOT_W'(is_off);
	end

	// candidates in emission order: zero slot, row pointer, data, end pointer
	always_comb begin
		cand_v[0] = first && !mat_end;
		cand_v[1] = (col_q == '0);
		cand_v[2] = is_diag || is_off;
		cand_v[3] = mat_end;

		cand_m[0] = '{dtsc_pkg::KIND_ZERO, dtsc_pkg::SLOT_W'(dims.rows), '0, '0, '0, 1'b0};
		cand_d[0] = zero_value;

		cand_m[1] = '{dtsc_pkg::KIND_ROWPTR, dtsc_pkg::SLOT_W'(row_q), '0, ns0, '0, 1'b0};
		cand_d[1] = '0;

		if (is_diag) begin
			cand_m[2] = '{dtsc_pkg::KIND_DIAG, dtsc_pkg::SLOT_W'(row_q), '0, '0, '0, 1'b0};
		end else begin
			cand_m[2] = '{dtsc_pkg::KIND_OFFDIAG, ns0, col_q, '0, '0, 1'b0};
		end
		cand_d[2] = element;

		cand_m[3] = '{dtsc_pkg::KIND_END, dtsc_pkg::SLOT_W'(dims.rows), '0, ns1,
			cnt1[dtsc_pkg::COUNT_W-1:0], 1'b1};
		cand_d[3] = zero_value;
	end

	// pack present candidates into consecutive slots
	always_comb begin
		logic [2:0] n;
		n = '0;
		set.meta = '0;
		for (int k = 0; k < 3; k++) begin
			vals[k] = '0;
		end
		for (int k = 0; k < 4; k++) begin
			if (cand_v[k] && (n < 3'd3)) begin
				set.meta[n[1:0]] = cand_m[k];
				vals[n[1:0]]     = cand_d[k];
				n = n + 3'd1;
			end
		end
		set.count = n[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			next_slot_q <= 17'd2;
			offdiag_q   <= '0;
		end else if (consume) begin
			next_slot_q <= ns1;
			offdiag_q   <= cnt1;
			if (mat_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (row_end) begin
				row_q <= row_q + 8'd1;
				col_q <= '0;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	`DTSC_ASSERT(a_set_fits, clk, arst_n, valid, $countones(cand_v) <= 3,
		"more than three results for one element")
	`DTSC_ASSERT_NEXT(a_wrap_origin, clk, arst_n, consume && mat_end,
		(row_q == '0) && (col_q == '0), "position did not return to origin")
	`DTSC_ASSERT(a_end_last, clk, arst_n, valid && mat_end && (set.count != 2'd0),
		set.meta[set.count - 2'd1].last, "end pointer is not the final beat of the set")

endmodule

`default_nettype wire

// ===== hw/rtl/dtsc_ser.sv =====
// ----------------------------------------------------------------------------
// dtsc_ser
// result bank that holds one element's results and sends them one per beat
// ----------------------------------------------------------------------------
`default_nettype none
`include "dense_to_sparse_compressor_core_assert.svh"

module dtsc_ser #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  set_valid,
	input  wire dtsc_pkg::res_set_t    set,
	input  wire logic [DATA_WIDTH-1:0] vals [3],
	output logic                       consume,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output dtsc_pkg::res_meta_t        out_meta,
	output logic [DATA_WIDTH-1:0]      out_value
);

	logic [1:0]            cnt_q;
	dtsc_pkg::res_meta_t   meta_q [3];
	logic [DATA_WIDTH-1:0] val_q  [3];
	logic                  pop;
	logic                  bank_free;
	logic                  load;

	always_comb begin
		out_valid = (cnt_q != 2'd0);
		pop       = out_valid && out_ready;
		bank_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
		// an element with no results passes even while the bank drains
		consume   = set_valid && ((set.count == 2'd0) || bank_free);
		load      = consume && (set.count != 2'd0);
		out_meta  = meta_q[0];
		out_value = val_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= set.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 3; k++) begin
				meta_q[k] <= set.meta[k];
				val_q[k]  <= vals[k];
			end
		end else if (pop) begin
			meta_q[0] <= meta_q[1];
			meta_q[1] <= meta_q[2];
			val_q[0]  <= val_q[1];
			val_q[1]  <= val_q[2];
		end
	end

	`DTSC_ASSERT(a_last_is_end, clk, arst_n, out_valid,
		out_meta.last == (out_meta.kind == dtsc_pkg::KIND_END),
		"last flag and end pointer kind disagree")

endmodule

`default_nettype wire

// ===== hw/rtl/dense_to_sparse_compressor_core.sv =====
// ----------------------------------------------------------------------------
// dense_to_sparse_compressor_core
// converts a row-major dense matrix stream into new-Yale sparse array writes
// ----------------------------------------------------------------------------
// usage
//  - elements: one dense element per beat, row-major, valid/ready
//  - results: one array write per beat (zero slot, row pointer, diagonal,
//    off-diagonal entry, end pointer); last marks the end pointer of a matrix
//  - cfg port: row_count (index 0), column_count (1), zero_value (2); write
//    only while no element is in flight and all results have been taken
//  - path: an accepted element is registered in the input register, then loaded
//    into the result bank, whose head presents its first result beat
//  - throughput: one element per cycle when it causes at most one result and
//    results.ready stays high; an element that causes n results occupies the
//    result port for n beats, so the rate is set by the one-beat-per-cycle
//    result port (up to three beats at row starts and at the matrix end)
//  - elements that cause no result pass without waiting for the result port
//  - receiver stall: results wait in the bank, one element waits in the input
//    register, then elements.ready drops
//  - reset: position returns to row 0 column 0, bank and input register empty,
//    registers load 1x1 shape with zero value 0
// ----------------------------------------------------------------------------
`default_nettype none

module dense_to_sparse_compressor_core #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	dtsc_in_if.sink                   elements,
	dtsc_out_if.source                results,
	input  wire logic                 cfg_wr_en,
	input  wire logic [dtsc_pkg::REG_W-1:0] cfg_index,
	input  wire logic [((DATA_WIDTH > dtsc_pkg::DIM_W) ? DATA_WIDTH
		: dtsc_pkg::DIM_W)-1:0]       cfg_wdata
);

	// configuration registers
	logic [dtsc_pkg::DIM_W-1:0] row_count_q;
	logic [dtsc_pkg::DIM_W-1:0] column_count_q;
	logic [DATA_WIDTH-1:0]      zero_value_q;
	dtsc_pkg::dims_t            dims;

	// input register
	logic                  valid_s1;
	logic [DATA_WIDTH-1:0] element_s1;

	dtsc_pkg::res_set_t    set;
	logic [DATA_WIDTH-1:0] vals [3];
	logic                  consume;
	logic                  out_valid;
	dtsc_pkg::res_meta_t   out_meta;
	logic [DATA_WIDTH-1:0] out_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= 9'd1;
			column_count_q <= 9'd1;
			zero_value_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dtsc_pkg::REG_ROW_COUNT: begin
					row_count_q <= cfg_wdata[dtsc_pkg::DIM_W-1:0];
				end
				dtsc_pkg::REG_COLUMN_COUNT: begin
					column_count_q <= cfg_wdata[dtsc_pkg::DIM_W-1:0];
				end
				dtsc_pkg::REG_ZERO_VALUE: begin
					zero_value_q <= cfg_wdata[DATA_WIDTH-1:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// saturate shape into 1..max
	always_comb begin
		if (row_count_q == '0) begin
			dims.rows = 9'd1;
		end else if (row_count_q > dtsc_pkg::DIM_W'(dtsc_pkg::MAX_ROWS)) begin
			dims.rows = dtsc_pkg::DIM_W'(dtsc_pkg::MAX_ROWS);
		end else begin
			dims.rows = row_count_q;
		end
		if (column_count_q == '0) begin
			dims.cols = 9'd1;
		end else if (column_count_q > dtsc_pkg::DIM_W'(dtsc_pkg::MAX_COLS)) begin
			dims.cols = dtsc_pkg::DIM_W'(dtsc_pkg::MAX_COLS);
		end else begin
			dims.cols = column_count_q;
		end
	end

	// input register frees itself in the same cycle its element is consumed
	assign elements.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (elements.valid && elements.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (elements.valid && elements.ready) begin
			element_s1 <= elements.element;
		end
	end

	dtsc_gen #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.consume    (consume),
		.element    (element_s1),
		.dims       (dims),
		.zero_value (zero_value_q),
		.set        (set),
		.vals       (vals)
	);

	dtsc_ser #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_valid (valid_s1),
		.set       (set),
		.vals      (vals),
		.consume   (consume),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.out_meta  (out_meta),
		.out_value (out_value)
	);

	// result beat straight from the head of the bank
	assign results.valid         = out_valid;
	assign results.kind          = out_meta.kind;
	assign results.address       = out_meta.address;
	assign results.column        = out_meta.column;
	assign results.value         = out_value;
	assign results.pointer       = out_meta.pointer;
	assign results.nonzero_count = out_meta.nonzero_count;
	assign results.last          = out_meta.last;

endmodule

`default_nettype wire
